@@ design/i2crw_pkg.sv @@
package i2crw_pkg;

  localparam int unsigned DelayBits = 16;
  localparam int unsigned CfgWidth  = 16;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [CfgIdxW-1:0] CfgDevAddr    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDataDelay  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgClockDelay = 2'd2;

  localparam logic [7:0]           DevAddrReset    = 8'hC0;
  localparam logic [CfgWidth-1:0]  DataDelayReset  = 16'd4;
  localparam logic [CfgWidth-1:0]  ClockDelayReset = 16'd4;

  typedef logic [DelayBits-1:0] hold_t;

  typedef struct packed {
    logic       start_req;
    logic [7:0] target_reg;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0]          dev_addr;
    logic [CfgWidth-1:0] data_delay;
    logic [CfgWidth-1:0] clock_delay;
  } cfg_t;

  typedef struct packed {
    logic done_res;
    logic busy_res;
    logic sda;
    logic scl;
  } res_t;

endpackage

@@ design/i2crw_seq.sv @@
module i2crw_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  i2crw_pkg::item_t item_i,
  input  i2crw_pkg::cfg_t  cfg_i,
  output i2crw_pkg::res_t  res_o
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_BIT   = 3'd2,
    PH_ACK   = 3'd3,
    PH_STOP  = 3'd4
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [1:0]         step_q, step_d;
  logic [3:0]         bit_q, bit_d;
  logic [1:0]         byte_q, byte_d;
  logic [7:0]         shift_q, shift_d;
  logic [15:0]        held_q, held_d;
  i2crw_pkg::hold_t   hold_q, hold_d;
  logic               scl_q, scl_d;
  logic               sda_q, sda_d;
  logic               busy, done;
  logic               enter;
  logic               clk_kind;
  i2crw_pkg::hold_t   dly_data, dly_clock;

  always_comb begin
    dly_data  = cfg_i.data_delay[i2crw_pkg::DelayBits-1:0];
    dly_clock = cfg_i.clock_delay[i2crw_pkg::DelayBits-1:0];
    if (dly_data == '0) dly_data = i2crw_pkg::hold_t'(1);
    if (dly_clock == '0) dly_clock = i2crw_pkg::hold_t'(1);
  end

  always_comb begin
    phase_d  = phase_q;
    step_d   = step_q;
    bit_d    = bit_q;
    byte_d   = byte_q;
    shift_d  = shift_q;
    held_d   = held_q;
    hold_d   = hold_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    busy     = 1'b0;
    done     = 1'b0;
    enter    = 1'b0;
    clk_kind = 1'b0;

    case (phase_q)
      PH_START, PH_BIT, PH_ACK, PH_STOP: ;
      default: phase_d = PH_IDLE;
    endcase

    if (phase_d == PH_IDLE && item_i.start_req) begin
      held_d  = {item_i.target_reg, item_i.data};
      shift_d = cfg_i.dev_addr;
      phase_d = PH_START;
      step_d  = 2'd0;
      bit_d   = 4'd0;
      byte_d  = 2'd0;
      sda_d   = 1'b1;
      hold_d  = dly_data;
    end

    res_o.scl = scl_d;
    res_o.sda = sda_d;

    if (phase_d != PH_IDLE) begin
      busy = 1'b1;
      if (hold_d != '0) hold_d = hold_d - i2crw_pkg::hold_t'(1);
      if (hold_d == '0) begin
        enter = 1'b1;
        case (phase_d)
          PH_START: begin
            if (step_d < 2'd3) begin
              step_d = step_d + 2'd1;
            end else begin
              phase_d = PH_BIT;
              step_d  = 2'd0;
              bit_d   = 4'd0;
              byte_d  = 2'd0;
            end
          end
          PH_BIT: begin
            if (step_d < 2'd2) begin
              step_d = step_d + 2'd1;
            end else begin
              shift_d = {shift_d[6:0], 1'b0};
              bit_d   = bit_d + 4'd1;
              step_d  = 2'd0;
              if (bit_d >= 4'd8) phase_d = PH_ACK;
            end
          end
          PH_ACK: begin
            if (step_d < 2'd2) begin
              step_d = step_d + 2'd1;
            end else begin
              step_d = 2'd0;
              byte_d = byte_d + 2'd1;
              if (byte_d == 2'd3) begin
                phase_d = PH_STOP;
              end else begin
                shift_d = (byte_d == 2'd1) ? held_d[15:8] : held_d[7:0];
                bit_d   = 4'd0;
                phase_d = PH_BIT;
              end
            end
          end
          default: begin
            if (step_d < 2'd2) begin
              step_d = step_d + 2'd1;
            end else begin
              phase_d = PH_IDLE;
              step_d  = 2'd0;
              hold_d  = '0;
              enter   = 1'b0;
              done    = 1'b1;
            end
          end
        endcase

        if (enter) begin
          case (phase_d)
            PH_START: begin
              case (step_d)
                2'd0: sda_d = 1'b1;
                2'd1: begin
                  scl_d    = 1'b1;
                  clk_kind = 1'b1;
                end
                2'd2: sda_d = 1'b0;
                default: scl_d = 1'b0;
              endcase
            end
            PH_BIT, PH_ACK: begin
              case (step_d)
                2'd0: sda_d = (phase_d == PH_BIT) ? shift_d[7] : 1'b0;
                2'd1: begin
                  scl_d    = 1'b1;
                  clk_kind = 1'b1;
                end
                default: scl_d = 1'b0;
              endcase
            end
            default: begin
              case (step_d)
                2'd0: sda_d = 1'b0;
                2'd1: begin
                  scl_d    = 1'b1;
                  clk_kind = 1'b1;
                end
                default: sda_d = 1'b1;
              endcase
            end
          endcase
          hold_d = clk_kind ? dly_clock : dly_data;
        end
      end
    end

    res_o.busy_res = busy;
    res_o.done_res = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      step_q  <= 2'd0;
      bit_q   <= 4'd0;
      byte_q  <= 2'd0;
      shift_q <= 8'd0;
      held_q  <= 16'd0;
      hold_q  <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
    end else if (step_i) begin
      phase_q <= phase_d;
      step_q  <= step_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      shift_q <= shift_d;
      held_q  <= held_d;
      hold_q  <= hold_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
    end
  end

  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.done_res |-> res_o.busy_res)
    else $error("done without busy");

  a_done_lines_high : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.done_res |-> (res_o.scl && res_o.sda))
    else $error("stop finished with a line low");

  a_bit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BIT) |-> (bit_q < 4'd8))
    else $error("bit index out of range");

  a_idle_lines_high : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (scl_q && sda_q))
    else $error("idle with a line low");

  a_done_to_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.done_res) |=> (phase_q == PH_IDLE))
    else $error("sequencer not idle after stop");

endmodule

@@ design/i2c_register_write_master_core.sv @@
// Write-only I2C register-write master, advanced one item per timing tick.
// Input stream: each item is one tick. tuser carries start_req; tdata carries
// the register byte and data. A start request while idle latches both bytes
// and the device address, then the core sends start, device address, register,
// data (each followed by a self-driven low ACK slot) and stop. Requests
// arriving while busy are dropped.
// Output stream: one item per input item with the SCL/SDA levels for that
// tick and busy_res over the whole transaction; tlast (done_res) marks its
// last tick.
// Configuration: cfg_we_i writes register cfg_idx_i (device address at 0,
// data delay at 1, clock delay at 2) from cfg_data_i; write only while idle.
// Pipeline: an accepted item passes the input register and then the result
// register; one item is taken every cycle unless the receiver stalls.
// Reset: both lines high, sequencer idle, registers at their defaults.
// Receiver stall: the result register holds and the input register stops
// accepting once it is full; the sequencer only advances on a moved item.
module i2c_register_write_master_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [15:0]                        s_axis_tdata,  // target_reg, data
  input  logic                               s_axis_tuser,  // start_req
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [7:0]                         m_axis_tdata,  // scl, sda, busy_res, 0
  output logic                               m_axis_tlast,  // done_res
  input  logic                               cfg_we_i,
  input  logic [i2crw_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [i2crw_pkg::CfgWidth-1:0]     cfg_data_i
);

  i2crw_pkg::cfg_t  cfg_q;
  i2crw_pkg::item_t in_q;
  logic             in_valid_q;
  i2crw_pkg::res_t  res;
  i2crw_pkg::res_t  out_q;
  logic             out_valid_q;
  logic             adv;
  logic             fire;

  assign adv           = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && adv;
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_addr    <= i2crw_pkg::DevAddrReset;
      cfg_q.data_delay  <= i2crw_pkg::DataDelayReset;
      cfg_q.clock_delay <= i2crw_pkg::ClockDelayReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        i2crw_pkg::CfgDevAddr:    cfg_q.dev_addr    <= cfg_data_i[7:0];
        i2crw_pkg::CfgDataDelay:  cfg_q.data_delay  <= cfg_data_i;
        i2crw_pkg::CfgClockDelay: cfg_q.clock_delay <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.start_req  <= s_axis_tuser;
      in_q.target_reg <= s_axis_tdata[7:0];
      in_q.data       <= s_axis_tdata[15:8];
    end
  end

  i2crw_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_q.busy_res, out_q.sda, out_q.scl};
  assign m_axis_tlast  = out_q.done_res;

endmodule
